// File: hdl/wlqe_pkg.sv
// Shared types, constants and helpers for the wide line quad expander.
package wlqe_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int FRAC_BITS       = 4;
   localparam int MAG_BITS        = 20;
   localparam int DIFF_W          = COORD_WIDTH + 1;
   localparam int MAG_W           = (DIFF_W > MAG_BITS) ? DIFF_W : MAG_BITS;
   localparam int SQ_W            = 2 * MAG_BITS;
   localparam int SUM_W           = SQ_W + 1;
   localparam int ACC_W           = SQ_W + 2 * FRAC_BITS + 6;
   localparam int K_W             = FRAC_BITS + 2;
   localparam int KMAX            = (1 << FRAC_BITS) + 1;
   localparam int H_W             = K_W + 1;

   localparam int VCNT_W          = 17;
   localparam int ICNT_W          = 18;
   localparam int COUNT_W         = 16;
   localparam int COLOR_W         = 32;
   localparam int TEX_W           = 16;
   localparam int INDEX_W         = 16;
   localparam int VERTS_PER_SEG   = 4;
   localparam int IDX_PER_SEG     = 6;
   localparam int RESULTS_PER_SEG = VERTS_PER_SEG + IDX_PER_SEG;
   localparam int EMIT_W          = $clog2(RESULTS_PER_SEG);

   localparam int REQ_FIELDS_W    = 2 * COORD_WIDTH + COUNT_W + 1 + COLOR_W + 1;
   localparam int REQ_DATA_W      = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W    = 2 * COORD_WIDTH + 2 * TEX_W + COLOR_W + INDEX_W;
   localparam int RSP_DATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LIMIT  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXEL_U      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXEL_V      = 8'd3;

   localparam logic [VCNT_W-1:0] VERTEX_LIMIT_RESET = 17'd65536;
   localparam logic [ICNT_W-1:0] INDEX_LIMIT_RESET  = 18'd196608;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_CHECK,
      ST_SHIFT,
      ST_HX,
      ST_HX_WAIT,
      ST_HY,
      ST_HY_WAIT,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      HN_IDLE,
      HN_SQ_A,
      HN_SQ_B,
      HN_ITER
   } hn_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } hn_stat_type;

   // vertex offset within the quad for each index result (two triangles)
   function automatic logic [1:0] idx_offset(input logic [EMIT_W-1:0] slot);
      logic [1:0] off;
      off = 2'd0;
      case (slot)
         4'd5:    off = 2'd1;
         4'd6:    off = 2'd2;
         4'd8:    off = 2'd2;
         4'd9:    off = 2'd3;
         default: off = 2'd0;
      endcase
      return off;
   endfunction

endpackage

// File: hdl/wlqe_hnorm.sv
// Iterative half unit normal component: largest k with (2k-1)^2 (a^2+b^2) <= a^2 4^F.
module wlqe_hnorm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wlqe_pkg::MAG_BITS-1:0]     mag_a,
   input  logic [wlqe_pkg::MAG_BITS-1:0]     mag_b,
   output wlqe_pkg::hn_stat_type             stat,
   output logic [wlqe_pkg::K_W-1:0]          half_mag
);

   wlqe_pkg::hn_state_type state_ff, state_in;

   logic [wlqe_pkg::MAG_BITS-1:0] a_ff, b_ff;
   logic [wlqe_pkg::SQ_W-1:0]     aa_ff;
   logic [wlqe_pkg::ACC_W-1:0]    lhs_ff, acc_ff, step_ff, inc_ff;
   logic [wlqe_pkg::K_W-1:0]      k_ff, m_ff;
   logic                          done_ff, done_in;

   logic [wlqe_pkg::MAG_BITS-1:0] mul_op;
   logic [wlqe_pkg::SQ_W-1:0]     prod;
   logic [wlqe_pkg::SUM_W-1:0]    sum;
   logic                          hit;

   // one multiplier, used for a^2 and then b^2
   assign mul_op = (state_ff == wlqe_pkg::HN_SQ_A) ? a_ff : b_ff;
   assign prod   = wlqe_pkg::SQ_W'(mul_op) * wlqe_pkg::SQ_W'(mul_op);
   assign sum    = {1'b0, aa_ff} + {1'b0, prod};
   assign hit    = (lhs_ff >= acc_ff) && (k_ff <= wlqe_pkg::K_W'(wlqe_pkg::KMAX));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlqe_pkg::HN_IDLE: if (start) state_in = wlqe_pkg::HN_SQ_A;
         wlqe_pkg::HN_SQ_A: state_in = wlqe_pkg::HN_SQ_B;
         wlqe_pkg::HN_SQ_B: begin
            if (sum == '0) state_in = wlqe_pkg::HN_IDLE;
            else state_in = wlqe_pkg::HN_ITER;
         end
         wlqe_pkg::HN_ITER: if (!hit) state_in = wlqe_pkg::HN_IDLE;
         default: state_in = wlqe_pkg::HN_IDLE;
      endcase
   end

   always_comb begin
      done_in = 1'b0;
      unique case (state_ff)
         wlqe_pkg::HN_SQ_B: done_in = (sum == '0);
         wlqe_pkg::HN_ITER: done_in = !hit;
         default:           done_in = 1'b0;
      endcase
      stat.busy = (state_ff != wlqe_pkg::HN_IDLE);
      stat.done = done_ff;
      half_mag  = m_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wlqe_pkg::HN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         wlqe_pkg::HN_IDLE: begin
            if (start) begin
               a_ff <= mag_a;
               b_ff <= mag_b;
            end
         end
         wlqe_pkg::HN_SQ_A: aa_ff <= prod;
         wlqe_pkg::HN_SQ_B: begin
            lhs_ff  <= wlqe_pkg::ACC_W'(aa_ff) << (2 * wlqe_pkg::FRAC_BITS);
            acc_ff  <= wlqe_pkg::ACC_W'(sum);
            step_ff <= wlqe_pkg::ACC_W'(sum) << 3;
            inc_ff  <= wlqe_pkg::ACC_W'(sum) << 3;
            k_ff    <= wlqe_pkg::K_W'(1);
            m_ff    <= '0;
         end
         wlqe_pkg::HN_ITER: begin
            // (2k+1)^2 - (2k-1)^2 = 8k, so the bound grows by a running step
            if (hit) begin
               m_ff    <= k_ff;
               acc_ff  <= acc_ff + step_ff;
               step_ff <= step_ff + inc_ff;
               k_ff    <= k_ff + wlqe_pkg::K_W'(1);
            end
         end
         default: ;
      endcase
   end

endmodule

// File: hdl/wide_line_quad_expander.sv
// Polyline to quad expander: sequencer, counters, output register.
//
// Points arrive on req_* one transfer at a time; each segment between
// consecutive points (plus the closing one for closed polylines) yields
// four vertex results and then six index results on rsp_*, the last one
// of an input marked with rsp_tlast. rsp_tuser is 0 for a vertex, 1 for
// an index. csr_* writes the limits and the texel; it is always ready.
// For each segment the shared half-normal unit iterates once per
// candidate step for each of the two offset components, and the
// ten results leave through one output register, one per cycle while
// rsp_tready stays high. Differences wider than the unit's input are
// shifted right one bit per cycle first.
// req_tready is high only while no input is being worked on.
// A stalled receiver holds the sequencer until the output register empties.
// Reset restores the register defaults, clears the counters and the
// polyline state and empties the output register; no clearing pass.
module wide_line_quad_expander (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pos_x, pos_y, point_count, closed, line_color, new_frame
   input  logic [wlqe_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // vert_x, vert_y, tex_u, tex_v, vert_color, index_value
   output logic [wlqe_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // kind
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wlqe_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wlqe_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int CW  = wlqe_pkg::COORD_WIDTH;
   localparam int DW  = wlqe_pkg::DIFF_W;
   localparam int P_Y = CW;
   localparam int P_N = 2 * CW;
   localparam int P_C = P_N + wlqe_pkg::COUNT_W;
   localparam int P_L = P_C + 1;
   localparam int P_F = P_L + wlqe_pkg::COLOR_W;

   wlqe_pkg::seq_state_type state_ff, state_in;

   logic [wlqe_pkg::VCNT_W-1:0]  vertex_limit_ff;
   logic [wlqe_pkg::ICNT_W-1:0]  index_limit_ff;
   logic [wlqe_pkg::TEX_W-1:0]   texel_u_ff, texel_v_ff;

   logic signed [CW-1:0]         first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [wlqe_pkg::COUNT_W-1:0] points_seen_ff;
   logic                         dropping_ff;
   logic [wlqe_pkg::VCNT_W-1:0]  vertex_used_ff;
   logic [wlqe_pkg::ICNT_W-1:0]  index_used_ff;

   logic signed [CW-1:0]         it_x_ff, it_y_ff;
   logic [wlqe_pkg::COUNT_W-1:0] it_count_ff;
   logic                         it_closed_ff;
   logic [wlqe_pkg::COLOR_W-1:0] it_color_ff;

   logic signed [CW-1:0]         seg_ax_ff, seg_ay_ff, seg_bx_ff, seg_by_ff;
   logic [wlqe_pkg::MAG_W-1:0]   mag_x_ff, mag_y_ff;
   logic                         neg_x_ff, neg_y_ff;
   logic signed [wlqe_pkg::H_W-1:0] hx_ff, hy_ff;
   logic [wlqe_pkg::INDEX_W-1:0] base_ff;
   logic                         close_pend_ff, more_ff;
   logic [wlqe_pkg::EMIT_W-1:0]  emit_ff;

   logic                         rsp_valid_ff;
   logic [wlqe_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                         rsp_kind_ff, rsp_last_ff;

   // sequencer decisions
   logic                         accept, short_pt, first_pt, last_pt, fits, seg_ok, more;
   logic                         need_shift, slot_free, load_rsp, emit_last, hn_start;
   logic [wlqe_pkg::COUNT_W:0]   seen_next;
   logic [wlqe_pkg::COUNT_W:0]   seg_cnt;
   logic [19:0]                  need_v, need_i;
   logic signed [DW-1:0]         dx, dy;
   logic [DW-1:0]                abs_x, abs_y;

   wlqe_pkg::hn_stat_type        hn_stat;
   logic [wlqe_pkg::K_W-1:0]     hn_mag;
   logic [wlqe_pkg::MAG_BITS-1:0] hn_a, hn_b;
   logic signed [wlqe_pkg::H_W-1:0] h_signed;

   // result formatting
   logic signed [CW-1:0]         px, py, vx, vy;
   logic                         use_a, plus;
   logic [wlqe_pkg::INDEX_W-1:0] idx_val;
   logic [wlqe_pkg::RSP_DATA_W-1:0] rsp_data_in;

   function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] p,
                                                    input logic signed [wlqe_pkg::H_W-1:0] h,
                                                    input logic sub);
      logic signed [DW-1:0] pe, he, s;
      pe = {p[CW-1], p};
      he = {{(DW - wlqe_pkg::H_W){h[wlqe_pkg::H_W-1]}}, h};
      s  = sub ? (pe - he) : (pe + he);
      if (s[DW-1] != s[DW-2]) begin
         return s[DW-1] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
      end
      return s[CW-1:0];
   endfunction

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign short_pt  = (it_count_ff < wlqe_pkg::COUNT_W'(2));
   assign first_pt  = (points_seen_ff == '0);
   assign seen_next = {1'b0, points_seen_ff} + 17'd1;
   assign last_pt   = (seen_next >= {1'b0, it_count_ff});

   assign seg_cnt = it_closed_ff ? {1'b0, it_count_ff} : ({1'b0, it_count_ff} - 17'd1);
   assign need_v  = 20'(vertex_used_ff) + 20'({seg_cnt, 2'b00});
   assign need_i  = 20'(index_used_ff) + 20'({seg_cnt, 2'b00}) + 20'({seg_cnt, 1'b0});
   assign fits    = (need_v <= 20'(vertex_limit_ff)) && (need_i <= 20'(index_limit_ff));

   assign seg_ok = (20'(vertex_used_ff) + 20'(wlqe_pkg::VERTS_PER_SEG) <= 20'(vertex_limit_ff))
                && (20'(index_used_ff) + 20'(wlqe_pkg::IDX_PER_SEG) <= 20'(index_limit_ff));
   assign more   = close_pend_ff
                && (20'(vertex_used_ff) + 20'(2 * wlqe_pkg::VERTS_PER_SEG)
                    <= 20'(vertex_limit_ff))
                && (20'(index_used_ff) + 20'(2 * wlqe_pkg::IDX_PER_SEG)
                    <= 20'(index_limit_ff));

   assign dx    = {seg_bx_ff[CW-1], seg_bx_ff} - {seg_ax_ff[CW-1], seg_ax_ff};
   assign dy    = {seg_by_ff[CW-1], seg_by_ff} - {seg_ay_ff[CW-1], seg_ay_ff};
   assign abs_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign abs_y = dy[DW-1] ? DW'(-dy) : DW'(dy);

   assign need_shift = ((mag_x_ff >> wlqe_pkg::MAG_BITS) != '0)
                    || ((mag_y_ff >> wlqe_pkg::MAG_BITS) != '0);

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit_last = (emit_ff == wlqe_pkg::EMIT_W'(wlqe_pkg::RESULTS_PER_SEG - 1));

   assign hn_a = (state_ff == wlqe_pkg::ST_HY) ? mag_y_ff[wlqe_pkg::MAG_BITS-1:0]
                                               : mag_x_ff[wlqe_pkg::MAG_BITS-1:0];
   assign hn_b = (state_ff == wlqe_pkg::ST_HY) ? mag_x_ff[wlqe_pkg::MAG_BITS-1:0]
                                               : mag_y_ff[wlqe_pkg::MAG_BITS-1:0];
   assign h_signed = {1'b0, hn_mag};

   wlqe_hnorm u_hnorm (
      .clock    (clock),
      .reset    (reset),
      .start    (hn_start),
      .mag_a    (hn_a),
      .mag_b    (hn_b),
      .stat     (hn_stat),
      .half_mag (hn_mag)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlqe_pkg::ST_IDLE: if (accept) state_in = wlqe_pkg::ST_STEP;
         wlqe_pkg::ST_STEP: begin
            if (short_pt || first_pt || dropping_ff) state_in = wlqe_pkg::ST_IDLE;
            else state_in = wlqe_pkg::ST_CHECK;
         end
         wlqe_pkg::ST_CHECK: begin
            if (seg_ok) state_in = wlqe_pkg::ST_SHIFT;
            else state_in = wlqe_pkg::ST_IDLE;
         end
         wlqe_pkg::ST_SHIFT: if (!need_shift) state_in = wlqe_pkg::ST_HX;
         wlqe_pkg::ST_HX: state_in = wlqe_pkg::ST_HX_WAIT;
         wlqe_pkg::ST_HX_WAIT: if (hn_stat.done) state_in = wlqe_pkg::ST_HY;
         wlqe_pkg::ST_HY: state_in = wlqe_pkg::ST_HY_WAIT;
         wlqe_pkg::ST_HY_WAIT: if (hn_stat.done) state_in = wlqe_pkg::ST_EMIT;
         wlqe_pkg::ST_EMIT: begin
            if (slot_free && emit_last) begin
               if (close_pend_ff) state_in = wlqe_pkg::ST_CHECK;
               else state_in = wlqe_pkg::ST_IDLE;
            end
         end
         default: state_in = wlqe_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      hn_start   = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         wlqe_pkg::ST_IDLE: req_tready = 1'b1;
         wlqe_pkg::ST_HX:   hn_start   = 1'b1;
         wlqe_pkg::ST_HY:   hn_start   = 1'b1;
         wlqe_pkg::ST_EMIT: load_rsp   = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= wlqe_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_limit_ff <= wlqe_pkg::VERTEX_LIMIT_RESET;
         index_limit_ff  <= wlqe_pkg::INDEX_LIMIT_RESET;
         texel_u_ff      <= '0;
         texel_v_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wlqe_pkg::CSR_VERTEX_LIMIT: vertex_limit_ff <= csr_data[wlqe_pkg::VCNT_W-1:0];
            wlqe_pkg::CSR_INDEX_LIMIT:  index_limit_ff  <= csr_data[wlqe_pkg::ICNT_W-1:0];
            wlqe_pkg::CSR_TEXEL_U:      texel_u_ff      <= csr_data[wlqe_pkg::TEX_W-1:0];
            wlqe_pkg::CSR_TEXEL_V:      texel_v_ff      <= csr_data[wlqe_pkg::TEX_W-1:0];
            default: ;
         endcase
      end
   end

   // polyline state and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff     <= '0;
         first_y_ff     <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         points_seen_ff <= '0;
         dropping_ff    <= 1'b0;
         vertex_used_ff <= '0;
         index_used_ff  <= '0;
         close_pend_ff  <= 1'b0;
         more_ff        <= 1'b0;
      end else begin
         case (state_ff)
            wlqe_pkg::ST_IDLE: begin
               if (accept && req_tdata[P_F]) begin
                  vertex_used_ff <= '0;
                  index_used_ff  <= '0;
               end
            end
            wlqe_pkg::ST_STEP: begin
               prev_x_ff <= it_x_ff;
               prev_y_ff <= it_y_ff;
               if (short_pt) begin
                  points_seen_ff <= '0;
                  dropping_ff    <= 1'b0;
               end else if (first_pt) begin
                  first_x_ff     <= it_x_ff;
                  first_y_ff     <= it_y_ff;
                  dropping_ff    <= !fits;
                  points_seen_ff <= wlqe_pkg::COUNT_W'(1);
               end else begin
                  points_seen_ff <= last_pt ? '0 : seen_next[wlqe_pkg::COUNT_W-1:0];
                  close_pend_ff  <= last_pt && it_closed_ff;
               end
            end
            wlqe_pkg::ST_CHECK: begin
               more_ff <= more;
               if (seg_ok) begin
                  vertex_used_ff <= vertex_used_ff + wlqe_pkg::VCNT_W'(wlqe_pkg::VERTS_PER_SEG);
                  index_used_ff  <= index_used_ff + wlqe_pkg::ICNT_W'(wlqe_pkg::IDX_PER_SEG);
               end else begin
                  dropping_ff   <= 1'b1;
                  close_pend_ff <= 1'b0;
               end
            end
            wlqe_pkg::ST_EMIT: begin
               if (slot_free && emit_last) close_pend_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // item and segment datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         wlqe_pkg::ST_IDLE: begin
            if (accept) begin
               it_x_ff      <= req_tdata[P_Y-1:0];
               it_y_ff      <= req_tdata[P_N-1:P_Y];
               it_count_ff  <= req_tdata[P_C-1:P_N];
               it_closed_ff <= req_tdata[P_C];
               it_color_ff  <= req_tdata[P_F-1:P_L];
            end
         end
         wlqe_pkg::ST_STEP: begin
            seg_ax_ff <= prev_x_ff;
            seg_ay_ff <= prev_y_ff;
            seg_bx_ff <= it_x_ff;
            seg_by_ff <= it_y_ff;
         end
         wlqe_pkg::ST_CHECK: begin
            base_ff  <= vertex_used_ff[wlqe_pkg::INDEX_W-1:0];
            mag_x_ff <= wlqe_pkg::MAG_W'(abs_x);
            mag_y_ff <= wlqe_pkg::MAG_W'(abs_y);
            neg_x_ff <= dx[DW-1];
            neg_y_ff <= dy[DW-1];
            emit_ff  <= '0;
         end
         wlqe_pkg::ST_SHIFT: begin
            if (need_shift) begin
               mag_x_ff <= mag_x_ff >> 1;
               mag_y_ff <= mag_y_ff >> 1;
            end
         end
         wlqe_pkg::ST_HX_WAIT: begin
            if (hn_stat.done) hx_ff <= neg_x_ff ? -h_signed : h_signed;
         end
         wlqe_pkg::ST_HY_WAIT: begin
            if (hn_stat.done) hy_ff <= neg_y_ff ? -h_signed : h_signed;
         end
         wlqe_pkg::ST_EMIT: begin
            if (slot_free) begin
               emit_ff <= emit_ff + wlqe_pkg::EMIT_W'(1);
               if (emit_last) begin
                  // closing segment runs from the last point back to the first
                  seg_ax_ff <= it_x_ff;
                  seg_ay_ff <= it_y_ff;
                  seg_bx_ff <= first_x_ff;
                  seg_by_ff <= first_y_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // quad corners: a+n, b+n, b-n, a-n with n = (hy, -hx)
   always_comb begin
      use_a   = (emit_ff == '0) || (emit_ff == wlqe_pkg::EMIT_W'(3));
      plus    = (emit_ff < wlqe_pkg::EMIT_W'(2));
      px      = use_a ? seg_ax_ff : seg_bx_ff;
      py      = use_a ? seg_ay_ff : seg_by_ff;
      vx      = sat_add(px, hy_ff, !plus);
      vy      = sat_add(py, hx_ff, plus);
      idx_val = base_ff + wlqe_pkg::INDEX_W'(wlqe_pkg::idx_offset(emit_ff));
      if (emit_ff < wlqe_pkg::EMIT_W'(wlqe_pkg::VERTS_PER_SEG)) begin
         rsp_data_in = wlqe_pkg::RSP_DATA_W'({it_color_ff, texel_v_ff, texel_u_ff, vy, vx});
      end else begin
         rsp_data_in = wlqe_pkg::RSP_DATA_W'(idx_val)
                       << (2 * CW + 2 * wlqe_pkg::TEX_W + wlqe_pkg::COLOR_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= (emit_ff < wlqe_pkg::EMIT_W'(wlqe_pkg::VERTS_PER_SEG))
                        ? wlqe_pkg::KIND_VERTEX : wlqe_pkg::KIND_INDEX;
         rsp_last_ff <= emit_last && !more_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !hn_stat.busy)
      else $error("point accepted while normal unit busy");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == wlqe_pkg::KIND_INDEX))
      else $error("final result of a point is not an index");

   a_index_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == wlqe_pkg::KIND_INDEX)
      |-> (rsp_tdata[2 * CW + 2 * wlqe_pkg::TEX_W + wlqe_pkg::COLOR_W - 1:0] == '0))
      else $error("index result carries vertex data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second point taken before the first was processed");
`endif

endmodule
